// ===== sv/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcr_pkg;

  // fixed field widths of the result item
  localparam int PIX_W        = 14;
  localparam int ADDR_W       = 24;
  localparam int FRAME_W      = 13;
  localparam int OUT_FIELDS_W = 2 * PIX_W + ADDR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_USER_W   = 2;

  // tuser bit positions on the result channel
  localparam int USER_IN_FRAME = 0;
  localparam int USER_FINISHED = 1;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(640);
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(480);

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // input command codes (in_tuser)
  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;

  localparam logic [2:0] START_LAST_IDX = 3'd3;
  localparam logic [2:0] STEP_LAST_IDX  = 3'd7;

endpackage

// ===== sv/mcr_fifo.sv =====
// Small job queue between the command front end and the point generator.
// Depends on mcr_pkg for the queue depth.
`timescale 1ns / 1ps

module mcr_fifo
  import mcr_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0]   mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full      = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/mcr_front.sv =====
// Command front end: accepts items, keeps the circle state and runs one
// midpoint iteration per step, queuing a job for the point generator. Uses mcr_pkg.
`timescale 1ns / 1ps

module mcr_front
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 8,
  parameter int IN_DATA_W   = 32,
  parameter int JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 job_push,
  output logic [JOB_W-1:0]     job_data,
  input  logic                 job_full
);

  localparam int EW = RADIUS_BITS + 2;

  logic [COORD_BITS-1:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RADIUS_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [EW-1:0]   err_r, err_nxt;
  logic                   busy_r, busy_nxt;

  logic [COORD_BITS-1:0]  cx_in, cy_in;
  logic [RADIUS_BITS-1:0] r_in;
  logic                   accept, is_start, step_ok, fin;
  logic signed [EW-1:0]   e1, e2;

  assign cx_in = in_tdata[COORD_BITS-1:0];
  assign cy_in = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign r_in  = in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

  assign in_tready = !job_full;
  assign accept    = in_tvalid && in_tready;
  assign is_start  = (func_t'(in_tuser) == FUNC_START);
  assign step_ok   = busy_r && (y_r < x_r);

  // error update: subtract 2y+1, on a negative result add 2x-1 and pull x in
  assign e1 = err_r - $signed({1'b0, y_r, 1'b1});
  assign e2 = e1 + $signed({1'b0, x_r, 1'b0}) - $signed(EW'(1));

  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    err_nxt  = err_r;
    busy_nxt = busy_r;
    job_push = 1'b0;
    if (accept) begin
      if (is_start) begin
        cx_nxt   = cx_in;
        cy_nxt   = cy_in;
        x_nxt    = r_in;
        y_nxt    = '0;
        err_nxt  = $signed({2'b00, r_in});
        busy_nxt = (r_in != '0);
        job_push = 1'b1;
      end else if (step_ok) begin
        y_nxt = y_r + 1'b1;
        if (e1[EW-1]) begin
          err_nxt = e2;
          x_nxt   = x_r - 1'b1;
        end else begin
          err_nxt = e1;
        end
        busy_nxt = (y_nxt < x_nxt);
        job_push = 1'b1;
      end
    end
  end

  assign fin      = !busy_nxt;
  assign job_data = {fin, is_start, y_nxt, x_nxt, cy_nxt, cx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      x_r    <= '0;
      y_r    <= '0;
      err_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      err_r  <= err_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== sv/mcr_back.sv =====
// Point generator: walks a queued job's 4 or 8 symmetric points, then
// clips and computes the frame-buffer address in a two-stage pipeline. Uses mcr_pkg.
`timescale 1ns / 1ps

module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 8,
  parameter int JOB_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  logic [JOB_W-1:0]      job_data,
  output logic                  job_pop,
  input  logic [FRAME_W-1:0]    frame_width,
  input  logic [FRAME_W-1:0]    frame_height,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic [OUT_USER_W-1:0] out_tuser
);

  localparam int W  = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int CW = W + FRAME_W;
  localparam int MW = 2 * FRAME_W;

  logic [COORD_BITS-1:0]  j_cx, j_cy;
  logic [RADIUS_BITS-1:0] j_x, j_y;
  logic                   j_start, j_fin;

  logic signed [W-1:0] cxs, cys, xs, ys, px, py;
  logic [2:0]          idx_r, idx_nxt;
  logic                pt_last, issue, s1_en, out_en;

  logic                s1_v_r, s1_v_nxt;
  logic signed [W-1:0] s1_px_r, s1_py_r;
  logic                s1_last_r, s1_fin_r;

  logic                out_v_r, out_v_nxt;
  logic [PIX_W-1:0]    out_px_r, out_py_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_in_r, out_last_r, out_fin_r;

  logic                pt_in_frame;
  logic [MW-1:0]       prod;
  logic [ADDR_W-1:0]   addr;

  assign {j_fin, j_start, j_y, j_x, j_cy, j_cx} = job_data;

  assign cxs = $signed({{(W-COORD_BITS){1'b0}}, j_cx});
  assign cys = $signed({{(W-COORD_BITS){1'b0}}, j_cy});
  assign xs  = $signed({{(W-RADIUS_BITS){1'b0}}, j_x});
  assign ys  = $signed({{(W-RADIUS_BITS){1'b0}}, j_y});

  // point order; a start job carries x = radius and y = 0
  always_comb begin
    px = cxs;
    py = cys;
    if (j_start) begin
      case (idx_r[1:0])
        2'd0:    begin px = cxs;      py = cys + xs; end
        2'd1:    begin px = cxs;      py = cys - xs; end
        2'd2:    begin px = cxs + xs; py = cys;      end
        2'd3:    begin px = cxs - xs; py = cys;      end
        default: begin px = cxs;      py = cys;      end
      endcase
    end else begin
      case (idx_r)
        3'd0:    begin px = cxs + xs; py = cys + ys; end
        3'd1:    begin px = cxs - xs; py = cys + ys; end
        3'd2:    begin px = cxs - xs; py = cys - ys; end
        3'd3:    begin px = cxs + xs; py = cys - ys; end
        3'd4:    begin px = cxs + ys; py = cys + xs; end
        3'd5:    begin px = cxs - ys; py = cys + xs; end
        3'd6:    begin px = cxs - ys; py = cys - xs; end
        3'd7:    begin px = cxs + ys; py = cys - xs; end
        default: begin px = cxs;      py = cys;      end
      endcase
    end
  end

  assign out_en  = !out_v_r || out_tready;
  assign s1_en   = !s1_v_r || out_en;
  assign issue   = job_valid && s1_en;
  assign pt_last = j_start ? (idx_r == START_LAST_IDX) : (idx_r == STEP_LAST_IDX);
  assign job_pop = issue && pt_last;

  always_comb begin
    idx_nxt = idx_r;
    if (issue) begin
      idx_nxt = pt_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_en) begin
      s1_v_nxt = issue;
    end
    out_v_nxt = out_v_r;
    if (out_en) begin
      out_v_nxt = s1_v_r;
    end
  end

  // clip and address from the stage-1 point
  assign pt_in_frame = !s1_px_r[W-1] && !s1_py_r[W-1] &&
                       (CW'($unsigned(s1_px_r)) < CW'(frame_width)) &&
                       (CW'($unsigned(s1_py_r)) < CW'(frame_height));
  assign prod = MW'(FRAME_W'($unsigned(s1_py_r))) * MW'(frame_width)
              + MW'(FRAME_W'($unsigned(s1_px_r)));
  assign addr = pt_in_frame ? prod[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_px_r   <= px;
      s1_py_r   <= py;
      s1_last_r <= pt_last;
      s1_fin_r  <= j_fin;
    end
    if (out_en && s1_v_r) begin
      out_px_r   <= PIX_W'(s1_px_r);
      out_py_r   <= PIX_W'(s1_py_r);
      out_addr_r <= addr;
      out_in_r   <= pt_in_frame;
      out_last_r <= s1_last_r;
      out_fin_r  <= s1_fin_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_addr_r, out_py_r, out_px_r};
  always_comb begin
    out_tuser                = '0;
    out_tuser[USER_IN_FRAME] = out_in_r;
    out_tuser[USER_FINISHED] = out_fin_r;
  end

endmodule

// ===== sv/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer top level: frame-size registers, command front end,
// job queue and point generator. Depends on mcr_pkg, mcr_front, mcr_fifo, mcr_back.
// The first point of an item passes the queue entry, the point stage and the output
// register before it is offered. Throughput: one point per cycle through the single
// result port unless out_tready stalls it; a start item yields 4 points and a step
// item 8; a step on an idle circle yields no item.
// Reset: synchronous active-low; circle state cleared, frame size 640 x 480.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer
  import mcr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 8
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  // in_tdata: center_x, center_y, radius (lowest first), zero padded to bytes
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  input  logic [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0]     in_tdata,
  // in_tuser: func
  input  logic                                              in_tuser,
  // out_tdata: pixel_x, pixel_y, pixel_address (lowest first), zero padded
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  output logic [OUT_DATA_W-1:0]                             out_tdata,
  output logic                                              out_tlast,
  // out_tuser: in_frame, finished (lowest first)
  output logic [OUT_USER_W-1:0]                             out_tuser,
  input  logic                                              cfg_psel,
  input  logic                                              cfg_penable,
  input  logic                                              cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]                             cfg_paddr,
  input  logic [CFG_DATA_W-1:0]                             cfg_pwdata,
  output logic [CFG_DATA_W-1:0]                             cfg_prdata,
  output logic                                              cfg_pready
);

  localparam int IN_DATA_W = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
  localparam int JOB_W     = 2 * COORD_BITS + 2 * RADIUS_BITS + 2;

  logic [FRAME_W-1:0] frame_width_r, frame_width_nxt;
  logic [FRAME_W-1:0] frame_height_r, frame_height_nxt;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  logic               job_push, job_full, job_pop, job_valid;
  logic [JOB_W-1:0]   job_in, job_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_pwdata[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_pwdata[FRAME_W-1:0];
        default:          frame_width_nxt  = frame_width_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  mcr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .IN_DATA_W   (IN_DATA_W),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .job_push  (job_push),
    .job_data  (job_in),
    .job_full  (job_full)
  );

  mcr_fifo #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .not_empty (job_valid),
    .head_data (job_head)
  );

  mcr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_data     (job_head),
    .job_pop      (job_pop),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser)
  );

endmodule

// ===== dv/midpoint_circle_rasterizer_tb.sv =====
// Self-checking testbench for midpoint_circle_rasterizer: stream driver and point checker
// fed from a circle-walk predictor, frame size swept over the APB port. Depends on mcr_pkg.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_tb;
  import mcr_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int RADIUS_BITS  = 8;
  localparam int IN_DATA_W    = ((2*COORD_BITS+RADIUS_BITS+7)/8)*8;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 55;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    func_t                  func;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] r;
  } circle_cmd_t;

  typedef struct {
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic              in_frame;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              fin;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata: center_x, center_y, radius (lowest first)
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // in_tuser: func
  logic                  in_tuser = FUNC_START;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: pixel_x, pixel_y, pixel_address (lowest first), zero padded
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  // out_tuser: in_frame, finished (lowest first)
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  midpoint_circle_rasterizer #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  int frame_w = 640;
  int frame_h = 480;
  int ctr_col, ctr_row, oct_x, oct_y, dec_err;
  bit circle_active;

  circle_cmd_t cmd_q[$];
  pixel_t      pixel_q[$];
  circle_cmd_t cur_cmd;

  int in_wait, out_wait;
  bit in_calm, out_calm;
  int n_cmds, n_pixels, mismatches;

  function automatic int draw_idle(bit calm);
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void emit_pixel(int px, int py, bit last, bit fin);
    pixel_t p;
    bit in_frm;
    in_frm = px >= 0 && py >= 0 && px < frame_w && py < frame_h;
    p.px = PIX_W'(px);
    p.py = PIX_W'(py);
    p.in_frame = in_frm;
    p.addr = in_frm ? ADDR_W'(longint'(py) * frame_w + px) : '0;
    p.last = last;
    p.fin = fin;
    pixel_q.push_back(p);
  endfunction

  // one start or one midpoint iteration, expected points appended in output order
  function automatic void rasterize(circle_cmd_t c);
    int r;
    bit fin;
    if (c.func == FUNC_START) begin
      r = int'(c.r);
      ctr_col = int'(c.cx);
      ctr_row = int'(c.cy);
      oct_x = r;
      oct_y = 0;
      dec_err = r;
      circle_active = oct_y < oct_x;
      fin = !circle_active;
      emit_pixel(ctr_col, ctr_row + r, 1'b0, fin);
      emit_pixel(ctr_col, ctr_row - r, 1'b0, fin);
      emit_pixel(ctr_col + r, ctr_row, 1'b0, fin);
      emit_pixel(ctr_col - r, ctr_row, 1'b1, fin);
      return;
    end
    if (!circle_active || oct_y >= oct_x) return;
    dec_err -= 2 * oct_y + 1;
    oct_y += 1;
    if (dec_err < 0) begin
      dec_err += 2 * oct_x - 1;
      oct_x -= 1;
    end
    circle_active = oct_y < oct_x;
    fin = !circle_active;
    emit_pixel(ctr_col + oct_x, ctr_row + oct_y, 1'b0, fin);
    emit_pixel(ctr_col - oct_x, ctr_row + oct_y, 1'b0, fin);
    emit_pixel(ctr_col - oct_x, ctr_row - oct_y, 1'b0, fin);
    emit_pixel(ctr_col + oct_x, ctr_row - oct_y, 1'b0, fin);
    emit_pixel(ctr_col + oct_y, ctr_row + oct_x, 1'b0, fin);
    emit_pixel(ctr_col - oct_y, ctr_row + oct_x, 1'b0, fin);
    emit_pixel(ctr_col - oct_y, ctr_row - oct_x, 1'b0, fin);
    emit_pixel(ctr_col + oct_y, ctr_row - oct_x, 1'b1, fin);
  endfunction

  function automatic void note_mismatch(string why, pixel_t e, pixel_t a);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s point %0d: exp x=%0d y=%0d in=%0b addr=%0d last=%0b fin=%0b",
               $time, why, n_pixels,
               $signed(e.px), $signed(e.py), e.in_frame, e.addr, e.last, e.fin);
      $display("    act x=%0d y=%0d in=%0b addr=%0d last=%0b fin=%0b",
               $signed(a.px), $signed(a.py), a.in_frame, a.addr, a.last, a.fin);
    end
  endfunction

  function automatic void check_pixel();
    pixel_t e, a;
    e = '{default: '0};
    a.px = out_tdata[PIX_W-1:0];
    a.py = out_tdata[2*PIX_W-1:PIX_W];
    a.addr = out_tdata[2*PIX_W +: ADDR_W];
    a.in_frame = out_tuser[USER_IN_FRAME];
    a.fin = out_tuser[USER_FINISHED];
    a.last = out_tlast;
    if (pixel_q.size() == 0) begin
      note_mismatch("unexpected", e, a);
      return;
    end
    e = pixel_q.pop_front();
    if (a.px !== e.px || a.py !== e.py || a.in_frame !== e.in_frame ||
        a.addr !== e.addr || a.last !== e.last || a.fin !== e.fin)
      note_mismatch("wrong", e, a);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rasterize(cur_cmd);
        n_cmds++;
        if (n_cmds % 32 == 0) in_calm = ($urandom_range(0, 2) == 0);
        in_wait = draw_idle(in_calm);
      end
      if (!in_tvalid || in_tready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          cur_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_cmd.r, cur_cmd.cy, cur_cmd.cx};
          in_tuser <= cur_cmd.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // point checker; two long holds let the job queue back up into the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_pixel();
        n_pixels++;
        if (n_pixels % 64 == 0) out_calm = ($urandom_range(0, 2) == 0);
        out_wait = draw_idle(out_calm);
        if (n_pixels == 300 || n_pixels == 1500) out_wait = LONG_HOLD;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_cmd(func_t f, int cx, int cy, int r);
    circle_cmd_t c;
    c.func = f;
    c.cx = COORD_BITS'(cx);
    c.cy = COORD_BITS'(cy);
    c.r = RADIUS_BITS'(r);
    cmd_q.push_back(c);
  endtask

  task automatic queue_circle(int cx, int cy, int r, int steps);
    push_cmd(FUNC_START, cx, cy, r);
    repeat (steps) push_cmd(FUNC_STEP, 0, 0, 0);
  endtask

  function automatic int pick_coord(int span);
    int lim;
    lim = (span > 4095) ? 4095 : span;
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, lim + 16 > 4095 ? 4095 : lim + 16);
  endfunction

  // mostly whole circles, some abandoned early, plus raw noise items
  task automatic queue_random_phase(int target);
    int queued, r, full, n;
    queued = 0;
    while (queued < target) begin
      if ($urandom_range(0, 9) < 8) begin
        r = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
        full = (r * 3) / 4 + 2;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, full) : full;
        // keep the phase at its item budget; a long circle is cut short
        if (1 + n > target - queued) n = target - queued - 1;
        queue_circle(pick_coord(frame_w), pick_coord(frame_h), r, n);
        queued += 1 + n;
      end else begin
        push_cmd(func_t'($urandom_range(0, 1)), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 255));
        queued++;
      end
    end
  endtask

  // waits for the block to go quiet; a step on an idle circle yields nothing.
  // Sampled on the falling edge so the driver's updates have settled.
  task automatic settle();
    while (cmd_q.size() != 0 || in_tvalid || pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, int value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(int'(idx) * 4);
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = value & 32'h1FFF;
    else frame_h = value & 32'h1FFF;
  endtask

  task automatic set_frame(int w, int h);
    settle();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle step, zero radius, clipped extremes, restart while busy
    push_cmd(FUNC_STEP, 4095, 4095, 255);
    queue_circle(100, 100, 0, 1);
    queue_circle(0, 0, 255, 2);
    queue_circle(4095, 4095, 255, 2);
    queue_circle(320, 240, 10, 2);
    queue_circle(320, 240, 1, 2);
    queue_circle(639, 479, 5, 5);
    queue_circle(12'hAAA, 12'h555, 8'hAA, 1);
    queue_circle(12'h555, 12'hAAA, 8'h55, 1);

    queue_random_phase(PHASE_ITEMS);
    set_frame(4096, 4096);
    queue_random_phase(PHASE_ITEMS);
    set_frame(1, 1);
    queue_circle(0, 0, 1, 2);
    queue_random_phase(PHASE_ITEMS);
    set_frame(0, 0);
    queue_random_phase(PHASE_ITEMS);
    set_frame(8191, 8191);
    queue_circle(4095, 4095, 255, 3);
    queue_random_phase(PHASE_ITEMS);
    set_frame($urandom_range(1, 4096), $urandom_range(1, 4096));
    queue_random_phase(PHASE_ITEMS);
    settle();

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== midpoint_circle_rasterizer.f =====
sv/mcr_pkg.sv
sv/mcr_fifo.sv
sv/mcr_front.sv
sv/mcr_back.sv
sv/midpoint_circle_rasterizer.sv
dv/midpoint_circle_rasterizer_tb.sv
